/* hw/rtl/hcr_pkg.sv */
// Shared types and constants of the Harris corner response block.
package hcr_pkg;

    // Default size limits of the line memories.
    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_KAPPA        = 2'd2;

    // Register widths and reset values.
    localparam int FW_W    = 11;
    localparam int FH_W    = 13;
    localparam int KAPPA_W = 16;
    localparam int CFG_W   = 16;
    localparam logic [FW_W-1:0]    FW_RESET    = 11'd640;
    localparam logic [FH_W-1:0]    FH_RESET    = 13'd480;
    localparam logic [KAPPA_W-1:0] KAPPA_RESET = 16'd2621;

    // Datapath widths.
    localparam int PIX_W  = 8;
    localparam int GRAD_W = 11;
    localparam int PROD_W = 21;
    localparam int SUM_W  = 26;
    localparam int RESP_W = 50;

    // Luma weights, scaled by 256.
    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd150;
    localparam logic [7:0] LUMA_B = 8'd29;

    // First row and column that produce a response.
    localparam int FIRST_VALID = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic gray_step;
        logic grad_step;
        logic prod_step;
        logic win_step;
        logic sum_step;
        logic mul_step;
        logic fin_step;
        logic out_load;
        logic last;
    } hcr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } hcr_status_t;

endpackage

/* hw/rtl/hcr_stream_if.sv */
// Stream interfaces for pixel input and response output.
interface hcr_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;

    modport source (output valid, red, green, blue, frame_start, input ready);
    modport sink (input valid, red, green, blue, frame_start, output ready);
endinterface

interface hcr_result_if;
    logic               valid;
    logic               ready;
    logic signed [49:0] response;
    logic               frame_last;

    modport source (output valid, response, frame_last, input ready);
    modport sink (input valid, response, frame_last, output ready);
endinterface

/* hw/rtl/hcr_controller.sv */
// Sequencing state machine and frame position counters.
module hcr_controller #(
    parameter int MAX_WIDTH  = hcr_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = hcr_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       frame_start,
    output logic                       in_ready,
    input  logic [hcr_pkg::FW_W-1:0]   frame_width,
    input  logic [hcr_pkg::FH_W-1:0]   frame_height,
    input  hcr_pkg::hcr_status_t       status,
    output hcr_pkg::hcr_cmd_t          cmd,
    output logic [$clog2(MAX_WIDTH)-1:0] col_addr
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = (CW + 1 > hcr_pkg::FW_W) ? CW + 1 : hcr_pkg::FW_W;
    localparam int HW = (RW + 1 > hcr_pkg::FH_W) ? RW + 1 : hcr_pkg::FH_W;

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_GRAY  = 10'b0000000100,
        ST_GRAD  = 10'b0000001000,
        ST_PROD  = 10'b0000010000,
        ST_WIN   = 10'b0000100000,
        ST_SUM   = 10'b0001000000,
        ST_MUL   = 10'b0010000000,
        ST_FIN   = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   cur_col_reg;
    logic [CW-1:0]   clear_reg;
    logic            result_reg, last_reg;
    logic [WW-1:0]   ew, fw_ext, col_cur, col_inc;
    logic [HW-1:0]   eh, fh_ext, row_cur, row_inc;
    logic            accept;

    // Effective frame size, clamped to one and to the memory limits.
    always_comb
    begin
        fw_ext = WW'(frame_width);
        fh_ext = HW'(frame_height);
        if (frame_width == '0)
            ew = WW'(1);
        else if (fw_ext > WW'(MAX_WIDTH))
            ew = WW'(MAX_WIDTH);
        else
            ew = fw_ext;
        if (frame_height == '0)
            eh = HW'(1);
        else if (fh_ext > HW'(MAX_HEIGHT))
            eh = HW'(MAX_HEIGHT);
        else
            eh = fh_ext;
    end

    // Position of the incoming pixel and of the one after it.
    always_comb
    begin
        col_cur = frame_start ? '0 : WW'(col_reg);
        row_cur = frame_start ? '0 : HW'(row_reg);
        if (col_cur >= ew)
            col_cur = '0;
        if (row_cur >= eh)
            row_cur = '0;
        col_inc = col_cur + WW'(1);
        row_inc = row_cur + HW'(1);
        col_next = CW'(col_inc);
        row_next = RW'(row_cur);
        if (col_inc >= ew)
        begin
            col_next = '0;
            row_next = (row_inc >= eh) ? '0 : RW'(row_inc);
        end
    end

    // The clearing pass after reset walks every line memory address.
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign col_addr = (state_reg == ST_CLEAR) ? clear_reg
                    : (accept ? CW'(col_cur) : cur_col_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clear_reg == CW'(MAX_WIDTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid) state_next = ST_GRAY;
            ST_GRAY:  state_next = ST_GRAD;
            ST_GRAD:  state_next = ST_PROD;
            ST_PROD:  state_next = ST_WIN;
            ST_WIN:   state_next = result_reg ? ST_SUM : ST_IDLE;
            ST_SUM:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_FIN;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:   if (status.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.clear     = (state_reg == ST_CLEAR);
        cmd.load      = accept;
        cmd.gray_step = (state_reg == ST_GRAY);
        cmd.grad_step = (state_reg == ST_GRAD);
        cmd.prod_step = (state_reg == ST_PROD);
        cmd.win_step  = (state_reg == ST_WIN);
        cmd.sum_step  = (state_reg == ST_SUM);
        cmd.mul_step  = (state_reg == ST_MUL);
        cmd.fin_step  = (state_reg == ST_FIN);
        cmd.out_load  = (state_reg == ST_OUT) && status.out_free;
        cmd.last      = last_reg;
    end

    // State and position registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            col_reg     <= '0;
            row_reg     <= '0;
            cur_col_reg <= '0;
            clear_reg   <= '0;
            result_reg  <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clear_reg <= clear_reg + CW'(1);
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                cur_col_reg <= CW'(col_cur);
                result_reg  <= (row_cur >= HW'(hcr_pkg::FIRST_VALID))
                            && (col_cur >= WW'(hcr_pkg::FIRST_VALID));
                last_reg    <= (row_cur == eh - HW'(1)) && (col_cur == ew - WW'(1));
            end
        end
    end
endmodule

/* hw/rtl/hcr_datapath.sv */
// Gray conversion, Sobel gradients, line memories, windows and response math.
module hcr_datapath #(
    parameter int MAX_WIDTH = hcr_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hcr_pkg::hcr_cmd_t                 cmd,
    output hcr_pkg::hcr_status_t              status,
    input  logic [$clog2(MAX_WIDTH)-1:0]      col_addr,
    input  logic [hcr_pkg::PIX_W-1:0]         red,
    input  logic [hcr_pkg::PIX_W-1:0]         green,
    input  logic [hcr_pkg::PIX_W-1:0]         blue,
    input  logic [hcr_pkg::KAPPA_W-1:0]       kappa,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [hcr_pkg::RESP_W-1:0] response,
    output logic                              frame_last
);
    localparam int PW = hcr_pkg::PIX_W;
    localparam int GW = hcr_pkg::GRAD_W;
    localparam int QW = hcr_pkg::PROD_W;
    localparam int SW = hcr_pkg::SUM_W;
    localparam int RW = hcr_pkg::RESP_W;
    localparam int KW = hcr_pkg::KAPPA_W;
    localparam int DW = RW + 1;

    // Line memories: each entry holds the two previous rows of a column.
    logic [2*PW-1:0]   gray_mem [MAX_WIDTH];
    logic [6*QW-1:0]   prod_mem [MAX_WIDTH];
    logic [2*PW-1:0]   gray_rd_reg;
    logic [6*QW-1:0]   prod_rd_reg;

    logic [PW-1:0]     red_reg, green_reg, blue_reg;
    logic [PW-1:0]     gwin_reg [3][3];
    logic signed [QW-1:0] pwin_reg [3][3][3];
    logic signed [GW-1:0] gx_reg, gy_reg;
    logic signed [QW-1:0] pxx_reg, pxy_reg, pyy_reg;
    logic signed [SW-1:0] sxx_reg, sxy_reg, syy_reg, trace_reg;
    logic signed [DW-1:0] pa_reg, pb_reg, det_reg;
    logic [RW-1:0]        t2_reg, scaled_reg;
    logic                 out_valid_reg;
    logic signed [RW-1:0] response_reg;
    logic                 frame_last_reg;

    logic [PW+9:0]        luma;
    logic [PW-1:0]        gray;
    logic signed [GW-1:0] gx_next, gy_next;
    logic signed [SW-1:0] sxx_next, sxy_next, syy_next;
    logic [RW+KW-1:0]     kt2;
    logic signed [DW-1:0] resp_full;

    // Gray level of the latched pixel.
    always_comb
    begin
        luma = (PW+10)'(red_reg) * (PW+10)'(hcr_pkg::LUMA_R)
             + (PW+10)'(green_reg) * (PW+10)'(hcr_pkg::LUMA_G)
             + (PW+10)'(blue_reg) * (PW+10)'(hcr_pkg::LUMA_B);
        gray = luma[PW+7:8];
    end

    // Sobel gradients of the current gray window.
    always_comb
    begin
        gx_next = (GW'(gwin_reg[0][2]) + (GW'(gwin_reg[1][2]) <<< 1) + GW'(gwin_reg[2][2]))
                - (GW'(gwin_reg[0][0]) + (GW'(gwin_reg[1][0]) <<< 1) + GW'(gwin_reg[2][0]));
        gy_next = (GW'(gwin_reg[2][0]) + (GW'(gwin_reg[2][1]) <<< 1) + GW'(gwin_reg[2][2]))
                - (GW'(gwin_reg[0][0]) + (GW'(gwin_reg[0][1]) <<< 1) + GW'(gwin_reg[0][2]));
    end

    // Window sums of the three products.
    always_comb
    begin
        sxx_next = '0;
        sxy_next = '0;
        syy_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sxx_next = sxx_next + SW'(pwin_reg[0][i][j]);
                sxy_next = sxy_next + SW'(pwin_reg[1][i][j]);
                syy_next = syy_next + SW'(pwin_reg[2][i][j]);
            end
        end
    end

    assign kt2       = (RW+KW)'(t2_reg) * (RW+KW)'(kappa);
    assign resp_full = det_reg - DW'(scaled_reg);

    // Line memories with registered reads; zeroed by the clearing pass.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            gray_rd_reg <= gray_mem[col_addr];
            prod_rd_reg <= prod_mem[col_addr];
        end
        if (cmd.clear)
        begin
            gray_mem[col_addr] <= '0;
            prod_mem[col_addr] <= '0;
        end
        else
        begin
            if (cmd.gray_step)
                gray_mem[col_addr] <= {gray_rd_reg[PW-1:0], gray};
            if (cmd.win_step)
                prod_mem[col_addr] <= {prod_rd_reg[3*QW-1:0], pxx_reg, pxy_reg, pyy_reg};
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
        if (cmd.gray_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                gwin_reg[i][0] <= gwin_reg[i][1];
                gwin_reg[i][1] <= gwin_reg[i][2];
            end
            gwin_reg[0][2] <= gray_rd_reg[2*PW-1:PW];
            gwin_reg[1][2] <= gray_rd_reg[PW-1:0];
            gwin_reg[2][2] <= gray;
        end
        if (cmd.grad_step)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (cmd.prod_step)
        begin
            pxx_reg <= QW'(gx_reg) * QW'(gx_reg);
            pxy_reg <= QW'(gx_reg) * QW'(gy_reg);
            pyy_reg <= QW'(gy_reg) * QW'(gy_reg);
        end
        if (cmd.win_step)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pwin_reg[k][i][0] <= pwin_reg[k][i][1];
                    pwin_reg[k][i][1] <= pwin_reg[k][i][2];
                end
            end
            pwin_reg[0][0][2] <= prod_rd_reg[6*QW-1:5*QW];
            pwin_reg[1][0][2] <= prod_rd_reg[5*QW-1:4*QW];
            pwin_reg[2][0][2] <= prod_rd_reg[4*QW-1:3*QW];
            pwin_reg[0][1][2] <= prod_rd_reg[3*QW-1:2*QW];
            pwin_reg[1][1][2] <= prod_rd_reg[2*QW-1:QW];
            pwin_reg[2][1][2] <= prod_rd_reg[QW-1:0];
            pwin_reg[0][2][2] <= pxx_reg;
            pwin_reg[1][2][2] <= pxy_reg;
            pwin_reg[2][2][2] <= pyy_reg;
        end
        if (cmd.sum_step)
        begin
            sxx_reg   <= sxx_next;
            sxy_reg   <= sxy_next;
            syy_reg   <= syy_next;
            trace_reg <= sxx_next + syy_next;
        end
        if (cmd.mul_step)
        begin
            pa_reg <= DW'(sxx_reg) * DW'(syy_reg);
            pb_reg <= DW'(sxy_reg) * DW'(sxy_reg);
            t2_reg <= RW'(trace_reg) * RW'(trace_reg);
        end
        if (cmd.fin_step)
        begin
            det_reg    <= pa_reg - pb_reg;
            scaled_reg <= kt2[RW+KW-1:KW];
        end
        if (cmd.out_load)
        begin
            response_reg   <= resp_full[RW-1:0];
            frame_last_reg <= cmd.last;
        end
    end

    // Output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign response        = response_reg;
    assign frame_last      = frame_last_reg;
endmodule

/* hw/rtl/harris_corner_response.sv */
// Harris corner response: each accepted pixel passes the gray, gradient, product and
// window states; for a pixel at row >= 4 and column >= 4 the sum, multiply, finish and
// output states follow, and the output state loads the result and its valid register.
// Only one pixel at a time runs this single shared sequence; a held result stalls input.
// Reset restores the registers to 640 x 480 and kappa 2621, clears the position counters
// and the output, then a sweep of every address zeroes the line memories with ready low.
module harris_corner_response #(
    parameter int MAX_WIDTH  = hcr_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = hcr_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    hcr_pixel_if.sink                  pixel_in,
    hcr_result_if.source               result_out,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [hcr_pkg::CFG_W-1:0]  cfg_data
);
    logic [hcr_pkg::FW_W-1:0]    frame_width_reg;
    logic [hcr_pkg::FH_W-1:0]    frame_height_reg;
    logic [hcr_pkg::KAPPA_W-1:0] kappa_reg;
    hcr_pkg::hcr_cmd_t           cmd;
    hcr_pkg::hcr_status_t        status;
    logic [$clog2(MAX_WIDTH)-1:0] col_addr;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= hcr_pkg::FW_RESET;
            frame_height_reg <= hcr_pkg::FH_RESET;
            kappa_reg        <= hcr_pkg::KAPPA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hcr_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[hcr_pkg::FW_W-1:0];
                hcr_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[hcr_pkg::FH_W-1:0];
                hcr_pkg::CFG_KAPPA:        kappa_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer.
    hcr_controller #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_controller (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pixel_in.valid),
        .frame_start  (pixel_in.frame_start),
        .in_ready     (pixel_in.ready),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .status       (status),
        .cmd          (cmd),
        .col_addr     (col_addr)
    );

    // Arithmetic and storage.
    hcr_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .col_addr   (col_addr),
        .red        (pixel_in.red),
        .green      (pixel_in.green),
        .blue       (pixel_in.blue),
        .kappa      (kappa_reg),
        .out_valid  (result_out.valid),
        .out_ready  (result_out.ready),
        .response   (result_out.response),
        .frame_last (result_out.frame_last)
    );
endmodule

/* verif/hcr_tb_scoreboard.sv */
`timescale 1ns / 100ps
// Scoreboard class that predicts and checks the Harris corner responses.
class hcr_scoreboard;
    int unsigned frame_width;
    int unsigned frame_height;
    int unsigned kappa;
    int gray_lines[2][1024];
    int product_lines[3][2][1024];
    int gray_window[3][3];
    int product_windows[3][3][3];
    int unsigned column_count;
    int unsigned row_count;
    logic [49:0] response_queue[$];
    bit last_queue[$];
    int unsigned pixel_count;
    int unsigned response_count;

    function new();
        frame_width = hcr_pkg::FW_RESET;
        frame_height = hcr_pkg::FH_RESET;
        kappa = hcr_pkg::KAPPA_RESET;
        foreach (gray_lines[i, j]) gray_lines[i][j] = 0;
        foreach (product_lines[p, i, j]) product_lines[p][i][j] = 0;
        foreach (gray_window[i, j]) gray_window[i][j] = 0;
        foreach (product_windows[p, i, j]) product_windows[p][i][j] = 0;
        column_count = 0;
        row_count = 0;
        pixel_count = 0;
        response_count = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [15:0] value);
        case (index)
            hcr_pkg::CFG_FRAME_WIDTH:  frame_width = value[10:0];
            hcr_pkg::CFG_FRAME_HEIGHT: frame_height = value[12:0];
            hcr_pkg::CFG_KAPPA:        kappa = value;
            default: ;
        endcase
    endfunction

    function int pending();
        return response_queue.size();
    endfunction

    // Shift a window one column left and load the new right column.
    function void shift_window(ref int w[3][3], input int t, input int m, input int b);
        for (int i = 0; i < 3; i++)
        begin
            w[i][0] = w[i][1];
            w[i][1] = w[i][2];
        end
        w[0][2] = t;
        w[1][2] = m;
        w[2][2] = b;
    endfunction

    // Advance the predicted pipeline by one accepted pixel.
    function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                             logic frame_start);
        int unsigned ew;
        int unsigned eh;
        int unsigned col;
        int unsigned row;
        int gray;
        int gx;
        int gy;
        int prod[3];
        int tmp[3][3];
        longint sum[3];
        longint det;
        longint unsigned trace;
        longint unsigned t2;
        longint unsigned scaled;
        longint resp;

        ew = (frame_width == 0) ? 1 : (frame_width > 1024 ? 1024 : frame_width);
        eh = (frame_height == 0) ? 1 : (frame_height > 4096 ? 4096 : frame_height);
        pixel_count++;
        if (frame_start)
        begin
            column_count = 0;
            row_count = 0;
        end
        if (column_count >= ew) column_count = 0;
        if (row_count >= eh) row_count = 0;
        col = column_count;
        row = row_count;

        gray = (77 * red + 150 * green + 29 * blue) >> 8;
        shift_window(gray_window, gray_lines[0][col], gray_lines[1][col], gray);
        gray_lines[0][col] = gray_lines[1][col];
        gray_lines[1][col] = gray;

        gx = (gray_window[0][2] + 2 * gray_window[1][2] + gray_window[2][2])
           - (gray_window[0][0] + 2 * gray_window[1][0] + gray_window[2][0]);
        gy = (gray_window[2][0] + 2 * gray_window[2][1] + gray_window[2][2])
           - (gray_window[0][0] + 2 * gray_window[0][1] + gray_window[0][2]);
        prod[0] = gx * gx;
        prod[1] = gx * gy;
        prod[2] = gy * gy;

        // Each product has its own line pair and summing window.
        for (int p = 0; p < 3; p++)
        begin
            tmp = product_windows[p];
            shift_window(tmp, product_lines[p][0][col], product_lines[p][1][col], prod[p]);
            product_windows[p] = tmp;
            product_lines[p][0][col] = product_lines[p][1][col];
            product_lines[p][1][col] = prod[p];
            sum[p] = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    sum[p] += tmp[i][j];
        end

        if (row >= 4 && col >= 4)
        begin
            det = sum[0] * sum[2] - sum[1] * sum[1];
            trace = longint'(sum[0] + sum[2]);
            t2 = trace * trace;
            scaled = (t2 >> 16) * kappa + (((t2 & 64'hFFFF) * kappa) >> 16);
            resp = det - longint'(scaled);
            response_queue.push_back(resp[49:0]);
            last_queue.push_back(row == eh - 1 && col == ew - 1);
        end

        column_count = col + 1;
        if (column_count >= ew)
        begin
            column_count = 0;
            row_count = row + 1;
            if (row_count >= eh) row_count = 0;
        end
    endfunction

    // Compare one response transaction with the oldest prediction.
    function string check_result(logic [49:0] response, logic frame_last);
        logic [49:0] want;
        bit want_last;
        string msg;

        msg = "";
        if (response_queue.size() == 0)
            return $sformatf("unexpected response %0d", $signed(response));
        want = response_queue.pop_front();
        want_last = last_queue.pop_front();
        response_count++;
        if (response !== want)
            msg = $sformatf("response %0d, predicted %0d (result %0d)",
                            $signed(response), $signed(want), response_count);
        if (frame_last !== want_last)
            msg = {msg, $sformatf(" frame_last %b, predicted %b (result %0d)",
                                  frame_last, want_last, response_count)};
        return msg;
    endfunction
endclass

/* verif/harris_corner_response_tb.sv */
`timescale 1ns / 100ps
// Top-level testbench of the Harris corner response block.
module harris_corner_response_tb;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [hcr_pkg::CFG_W-1:0] cfg_data;
    int mismatch_count;
    bit calm;
    int hold_request;
    hcr_scoreboard board;

    hcr_pixel_if pix ();
    hcr_result_if res ();

    harris_corner_response uut (
        .clk(clk),
        .rst_n(rst_n),
        .pixel_in(pix),
        .result_out(res),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #20ms;
        $display("Timeout waiting for responses");
        $display("Mismatches found");
        $finish;
    end

    task automatic report(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Receiver: random stalls, plus a long hold-off when requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= calm || ($urandom_range(99) >= 28);
        end
    end

    // Response checking; signals are stable at the falling edge.
    always @(negedge clk)
    begin
        string msg;
        if (rst_n && res.valid && res.ready)
        begin
            msg = board.check_result(res.response, res.frame_last);
            if (msg != "") report(msg);
        end
    end

    // Write one configuration register while the block is idle.
    task automatic write_reg(input logic [1:0] index, input int value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value[hcr_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_register(index, value[hcr_pkg::CFG_W-1:0]);
        @(posedge clk);
    endtask

    // Offer one pixel transaction, with an optional idle gap first.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic fs);
        if (!calm && $urandom_range(99) < 28)
        begin
            pix.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 28);
        end
        pix.valid <= 1'b1;
        pix.red <= r;
        pix.green <= g;
        pix.blue <= b;
        pix.frame_start <= fs;
        do @(negedge clk); while (!pix.ready);
        @(posedge clk);
        board.note_pixel(r, g, b, fs);
    endtask

    // Random pixel, often at the extremes to give large gradients.
    task automatic send_random(input logic fs);
        logic [7:0] c[3];
        for (int i = 0; i < 3; i++)
            case ($urandom_range(3))
                0: c[i] = 8'd0;
                1: c[i] = 8'd255;
                default: c[i] = 8'($urandom_range(255));
            endcase
        send_pixel(c[0], c[1], c[2], fs);
    endtask

    // Pause the sender until every predicted response has arrived.
    task automatic drain();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_frames(input int w, input int h, input int frames);
        for (int f = 0; f < frames; f++)
            for (int i = 0; i < w * h; i++)
                send_random(i == 0);
    endtask

    initial
    begin
        int w;
        int h;
        int n;
        mismatch_count = 0;
        calm = 1'b0;
        hold_request = 0;
        board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = hcr_pkg::CFG_FRAME_WIDTH;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.red = 8'd0;
        pix.green = 8'd0;
        pix.blue = 8'd0;
        pix.frame_start = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero sizes act as one and give no responses.
        write_reg(hcr_pkg::CFG_FRAME_WIDTH, 0);
        write_reg(hcr_pkg::CFG_FRAME_HEIGHT, 0);
        for (int i = 0; i < 4; i++) send_pixel(8'd255, 8'd255, 8'd255, i == 0);
        drain();

        // Extreme channel values and the extreme kappa values on small frames.
        write_reg(hcr_pkg::CFG_FRAME_WIDTH, 5);
        write_reg(hcr_pkg::CFG_FRAME_HEIGHT, 5);
        write_reg(hcr_pkg::CFG_KAPPA, 0);
        for (int i = 0; i < 25; i++)
            send_pixel((i % 2) ? 8'd255 : 8'd0, (i % 3) ? 8'd0 : 8'd255,
                       (i % 4 < 2) ? 8'd255 : 8'd0, i == 0);
        drain();
        write_reg(hcr_pkg::CFG_KAPPA, 65535);
        send_frames(6, 6, 1);
        // Pixels past the frame end wrap into a new frame.
        for (int i = 0; i < 36; i++) send_random(1'b0);
        drain();

        // Oversize registers clamp: the row wraps after 1024 columns, which the
        // narrow rows that follow reveal in their response positions.
        write_reg(hcr_pkg::CFG_FRAME_WIDTH, 2047);
        write_reg(hcr_pkg::CFG_FRAME_HEIGHT, 8191);
        write_reg(hcr_pkg::CFG_KAPPA, 2621);
        for (int i = 0; i < 1030; i++) send_random(i == 0);
        drain();
        // Long receiver hold-off fills the block.
        write_reg(hcr_pkg::CFG_FRAME_WIDTH, 8);
        hold_request = 400;
        for (int i = 0; i < 60; i++) send_random(1'b0);
        drain();

        // Shrinking the width mid-frame wraps the column.
        write_reg(hcr_pkg::CFG_FRAME_WIDTH, 10);
        write_reg(hcr_pkg::CFG_FRAME_HEIGHT, 12);
        for (int i = 0; i < 65; i++) send_random(i == 0);
        drain();
        write_reg(hcr_pkg::CFG_FRAME_WIDTH, 6);
        write_reg(hcr_pkg::CFG_KAPPA, 1);
        for (int i = 0; i < 60; i++) send_random(1'b0);
        drain();

        // Random phases; the first stretch runs with no idling on either side.
        n = 0;
        calm = 1'b1;
        while (n < 400)
        begin
            if (n > 150) calm = 1'b0;
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(5, 12);
            h = $urandom_range(5, 9);
            write_reg(hcr_pkg::CFG_FRAME_WIDTH, w);
            write_reg(hcr_pkg::CFG_FRAME_HEIGHT, h);
            write_reg(hcr_pkg::CFG_KAPPA, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                                   : $urandom_range(1000, 5000));
            if ($urandom_range(4) == 0)
            begin
                // Broken frame: restart partway through.
                for (int i = 0; i < $urandom_range(1, w * h); i++) send_random(i == 0);
                n += w * h;
            end
            send_frames(w, h, $urandom_range(1, 2));
            n += 2 * w * h;
            drain();
        end

        pix.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        for (int i = 0; i < board.pending(); i++)
            report("predicted response never arrived");
        $display("Run covered %0d pixels and %0d responses over clamped, minimal and",
                 board.pixel_count, board.response_count);
        $display("random frame sizes, extreme kappa, wraps, restarts and back-pressure.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
